// ----- design/bpa_pkg.sv -----
// Shared types, constants and codes for the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int NUM_LISTS  = MAX_ORDER + 1;
    localparam int IDX_W      = MAX_ORDER;
    localparam int LINK_W     = IDX_W + 1;
    localparam int ORD_W      = 5;
    localparam int CNT_W      = 17;
    localparam int ADDR_W     = 28;
    localparam int CFG_W      = 5;
    localparam int SHAMT_W    = 6;

    localparam logic [ORD_W-1:0] TOP_ORDER_MAX = ORD_W'(MAX_ORDER);
    localparam logic [CFG_W-1:0] CFG_RESET     = CFG_W'(16);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;

    // Null link: one past the last page.
    localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_BAD_PTR   = 3'd3,
        ST_NOT_USED  = 3'd4,
        ST_NOT_HEAD  = 3'd5
    } status_t;

    typedef struct packed {
        logic              req_type;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] block_address;
    } res_t;

    typedef struct packed {
        logic             head;
        logic             used;
        logic [ORD_W-1:0] order;
    } tag_t;

    // Control from the sequencer into the page store.
    typedef struct packed {
        logic  tag_we;
        idx_t  tag_waddr;
        tag_t  tag_wdata;
        idx_t  tag_raddr;
        logic  next_we;
        idx_t  next_waddr;
        link_t next_wdata;
        logic  prev_we;
        idx_t  prev_waddr;
        link_t prev_wdata;
        idx_t  link_raddr;
    } store_ctl_t;

    typedef struct packed {
        tag_t  tag;
        link_t next;
        link_t prev;
    } store_rd_t;

    typedef enum logic [2:0] {
        RET_ALLOC = 3'd0,
        RET_MRG1  = 3'd1,
        RET_MRG2  = 3'd2,
        RET_SPLIT = 3'd3,
        RET_FREE  = 3'd4
    } ret_t;

endpackage

// ----- design/buddy_page_allocator_core.sv -----
// Top level of the buddy page allocator: handshakes, order register and result register.
`timescale 1ns / 1ps

// Buddy page allocator over 2^T pages of 4096 bytes, T = min(total_order, 16).
// Each item is either an allocate (page count) or a free (byte address), and
// each gives exactly one result item with a status and, for a successful
// allocate, the byte address of the block. Items are handled one at a time by
// a small sequencer around a page store with one read and one write port per
// array (tags, next links, previous links); that store's ports set the pace.
// An allocate searches the lists upward from order zero, unlinks the block it
// finds and splits it as far as the page count allows; a free pushes the block
// back on its list and merges it with its buddy level by level, up to T levels.
// A zero page count or an invalid address finishes without a store access, a
// free of a page that is not a used block head after one tag read, and an
// allocate that finds no space after searching every list up to order T.
// After reset and after every write of total_order the block clears its tag
// store and stalls input items meanwhile; the write itself is always taken. A
// new item is accepted while a finished result still waits in the output register.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  req_t             in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output res_t             out_item
);

    logic [CFG_W-1:0] total_order_reg;
    logic [ORD_W-1:0] top_order;
    logic [ORD_W-1:0] init_order;
    logic             eng_idle;
    logic             eng_done;
    res_t             eng_result;
    logic             res_free;
    logic             out_valid_reg;
    res_t             out_item_reg;
    store_ctl_t       st_ctl;
    store_rd_t        st_rd;

    // Orders above the largest supported one saturate.
    assign top_order  = (total_order_reg > CFG_W'(MAX_ORDER)) ? TOP_ORDER_MAX :
                        ORD_W'(total_order_reg);
    assign init_order = (cfg_wr_data > CFG_W'(MAX_ORDER)) ? TOP_ORDER_MAX :
                        ORD_W'(cfg_wr_data);

    assign in_stall  = !eng_idle;
    assign res_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_order_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            total_order_reg <= cfg_wr_data;
        end
    end

    // Output register: the sequencer hands over a result only when it is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done && res_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done && res_free)
        begin
            out_item_reg <= eng_result;
        end
    end

    bpa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr_en),
        .init_order (init_order),
        .top_order  (top_order),
        .start      (in_valid && !in_stall),
        .req        (in_item),
        .res_free   (res_free),
        .idle       (eng_idle),
        .done       (eng_done),
        .result     (eng_result),
        .st         (st_ctl),
        .rd         (st_rd)
    );

    bpa_store u_store (
        .clk (clk),
        .ctl (st_ctl),
        .rd  (st_rd)
    );

endmodule

// ----- design/bpa_store.sv -----
// Per-page storage: block tags and free-list links, one write and one read port each.
`timescale 1ns / 1ps

module bpa_store
    import bpa_pkg::*;
(
    input  logic       clk,
    input  store_ctl_t ctl,
    output store_rd_t  rd
);

    tag_t  tag_mem  [1 << IDX_W];
    link_t next_mem [1 << IDX_W];
    link_t prev_mem [1 << IDX_W];

    always_ff @(posedge clk)
    begin
        if (ctl.tag_we)
        begin
            tag_mem[ctl.tag_waddr] <= ctl.tag_wdata;
        end
        rd.tag <= tag_mem[ctl.tag_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[ctl.next_waddr] <= ctl.next_wdata;
        end
        rd.next <= next_mem[ctl.link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prev_we)
        begin
            prev_mem[ctl.prev_waddr] <= ctl.prev_wdata;
        end
        rd.prev <= prev_mem[ctl.link_raddr];
    end

endmodule

// ----- design/bpa_engine.sv -----
// Sequencer for allocate, free, split and merge, with the free-list heads.
`timescale 1ns / 1ps

module bpa_engine
    import bpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic [ORD_W-1:0] init_order,
    input  logic [ORD_W-1:0] top_order,
    input  logic             start,
    input  req_t             req,
    input  logic             res_free,
    output logic             idle,
    output logic             done,
    output res_t             result,
    output store_ctl_t       st,
    input  store_rd_t        rd
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_CLEAR     = 14'b00000000000010,
        S_INIT      = 14'b00000000000100,
        S_A_SEARCH  = 14'b00000000001000,
        S_RM_RD     = 14'b00000000010000,
        S_RM_WR     = 14'b00000000100000,
        S_SPLIT     = 14'b00000001000000,
        S_PUSH_WR   = 14'b00000010000000,
        S_PUSH_LINK = 14'b00000100000000,
        S_F_RD      = 14'b00001000000000,
        S_F_CHK     = 14'b00010000000000,
        S_M_RD      = 14'b00100000000000,
        S_M_CHK     = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    idx_t             idx_reg, idx_next;
    idx_t             node_reg, node_next;
    idx_t             bud_reg, bud_next;
    logic [CNT_W-1:0] size_reg, size_next;
    link_t            link_reg, link_next;
    ret_t             ret_reg, ret_next;
    logic             clr_hi_reg, clr_hi_next;
    idx_t             clr_cnt_reg, clr_cnt_next;
    status_t          status_reg, status_next;
    logic             alloc_reg, alloc_next;
    link_t            head_reg [NUM_LISTS];

    logic             head_we;
    link_t            head_wdata;
    link_t            head_cur;
    logic [CNT_W-1:0] ord_pow;
    logic [CNT_W-1:0] half_pow;
    logic [SHAMT_W-1:0] shamt;
    idx_t             bud_calc;

    // The shared order unit: block size at the current order and half of it.
    assign head_cur = head_reg[ord_reg];
    assign ord_pow  = CNT_W'(1) << ord_reg;
    assign half_pow = ord_pow >> 1;
    assign shamt    = SHAMT_W'(PAGE_SHIFT) + SHAMT_W'(top_order);
    assign bud_calc = idx_reg ^ IDX_W'(ord_pow);

    always_comb
    begin
        state_next   = state_reg;
        ord_next     = ord_reg;
        idx_next     = idx_reg;
        node_next    = node_reg;
        bud_next     = bud_reg;
        size_next    = size_reg;
        link_next    = link_reg;
        ret_next     = ret_reg;
        clr_hi_next  = clr_hi_reg;
        clr_cnt_next = clr_cnt_reg;
        status_next  = status_reg;
        alloc_next   = alloc_reg;
        head_we      = 1'b0;
        head_wdata   = LINK_NIL;
        st           = '0;
        idle         = 1'b0;
        done         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                st.tag_we    = 1'b1;
                st.tag_waddr = clr_cnt_reg;
                st.tag_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                st.tag_we     = 1'b1;
                st.tag_waddr  = '0;
                st.tag_wdata  = '{head: 1'b1, used: 1'b0, order: top_order};
                st.next_we    = 1'b1;
                st.next_waddr = '0;
                st.next_wdata = LINK_NIL;
                st.prev_we    = 1'b1;
                st.prev_waddr = '0;
                st.prev_wdata = LINK_NIL;
                state_next    = S_IDLE;
            end

            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    size_next   = req.page_count;
                    ord_next    = '0;
                    status_next = ST_OK;
                    alloc_next  = (req.req_type == REQ_ALLOC);
                    idx_next    = req.address[PAGE_SHIFT +: IDX_W];
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req.page_count == '0)
                        begin
                            status_next = ST_ZERO_SIZE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_SEARCH;
                        end
                    end
                    else if ((req.address[PAGE_SHIFT-1:0] != '0) ||
                             ((req.address >> shamt) != '0))
                    begin
                        status_next = ST_BAD_PTR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end

            S_A_SEARCH:
            begin
                if ((ord_pow >= size_reg) && !head_cur[IDX_W])
                begin
                    idx_next   = head_cur[IDX_W-1:0];
                    node_next  = head_cur[IDX_W-1:0];
                    ret_next   = RET_ALLOC;
                    state_next = S_RM_RD;
                end
                else if (ord_reg >= top_order)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    ord_next = ord_reg + 1'b1;
                end
            end

            S_RM_RD:
            begin
                st.link_raddr = node_reg;
                state_next    = S_RM_WR;
            end

            S_RM_WR:
            begin
                if (!rd.prev[IDX_W])
                begin
                    st.next_we    = 1'b1;
                    st.next_waddr = rd.prev[IDX_W-1:0];
                    st.next_wdata = rd.next;
                end
                if (!rd.next[IDX_W])
                begin
                    st.prev_we    = 1'b1;
                    st.prev_waddr = rd.next[IDX_W-1:0];
                    st.prev_wdata = rd.prev;
                end
                if (head_cur == {1'b0, node_reg})
                begin
                    head_we    = 1'b1;
                    head_wdata = rd.next;
                end
                case (ret_reg)
                    RET_ALLOC:
                    begin
                        state_next = S_SPLIT;
                    end
                    RET_MRG1:
                    begin
                        node_next  = bud_reg;
                        ret_next   = RET_MRG2;
                        state_next = S_RM_RD;
                    end
                    default:
                    begin
                        // Both buddies are off the list: push the lower one a level up.
                        if (idx_reg < bud_reg)
                        begin
                            node_next = idx_reg;
                        end
                        else
                        begin
                            node_next = bud_reg;
                            idx_next  = bud_reg;
                            bud_next  = idx_reg;
                        end
                        ord_next    = ord_reg + 1'b1;
                        clr_hi_next = 1'b1;
                        ret_next    = RET_FREE;
                        state_next  = S_PUSH_WR;
                    end
                endcase
            end

            S_SPLIT:
            begin
                if ((ord_reg != '0) && (half_pow >= size_reg))
                begin
                    ord_next    = ord_reg - 1'b1;
                    node_next   = idx_reg | IDX_W'(half_pow);
                    clr_hi_next = 1'b0;
                    ret_next    = RET_SPLIT;
                    state_next  = S_PUSH_WR;
                end
                else
                begin
                    st.tag_we    = 1'b1;
                    st.tag_waddr = idx_reg;
                    st.tag_wdata = '{head: 1'b1, used: 1'b1, order: ord_reg};
                    status_next  = ST_OK;
                    state_next   = S_DONE;
                end
            end

            S_PUSH_WR:
            begin
                st.next_we    = 1'b1;
                st.next_waddr = node_reg;
                st.next_wdata = head_cur;
                st.prev_we    = 1'b1;
                st.prev_waddr = node_reg;
                st.prev_wdata = LINK_NIL;
                st.tag_we     = 1'b1;
                st.tag_waddr  = node_reg;
                st.tag_wdata  = '{head: 1'b1, used: 1'b0, order: ord_reg};
                head_we       = 1'b1;
                head_wdata    = {1'b0, node_reg};
                link_next     = head_cur;
                state_next    = S_PUSH_LINK;
            end

            S_PUSH_LINK:
            begin
                if (!link_reg[IDX_W])
                begin
                    st.prev_we    = 1'b1;
                    st.prev_waddr = link_reg[IDX_W-1:0];
                    st.prev_wdata = {1'b0, node_reg};
                end
                if (clr_hi_reg)
                begin
                    st.tag_we    = 1'b1;
                    st.tag_waddr = bud_reg;
                    st.tag_wdata = '0;
                end
                if (ret_reg == RET_SPLIT)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_M_RD;
                end
            end

            S_F_RD:
            begin
                st.tag_raddr = idx_reg;
                state_next   = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (!rd.tag.head)
                begin
                    status_next = ST_NOT_HEAD;
                    state_next  = S_DONE;
                end
                else if (!rd.tag.used)
                begin
                    status_next = ST_NOT_USED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ord_next    = rd.tag.order;
                    node_next   = idx_reg;
                    clr_hi_next = 1'b0;
                    ret_next    = RET_FREE;
                    state_next  = S_PUSH_WR;
                end
            end

            S_M_RD:
            begin
                if (ord_reg < top_order)
                begin
                    st.tag_raddr = bud_calc;
                    bud_next     = bud_calc;
                    state_next   = S_M_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_M_CHK:
            begin
                if (rd.tag == '{head: 1'b1, used: 1'b0, order: ord_reg})
                begin
                    node_next  = idx_reg;
                    ret_next   = RET_MRG1;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                done = 1'b1;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.status        = status_reg;
    assign result.block_address = (alloc_reg && (status_reg == ST_OK)) ?
                                  (ADDR_W'(idx_reg) << PAGE_SHIFT) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ret_reg     <= RET_ALLOC;
            clr_hi_reg  <= 1'b0;
            status_reg  <= ST_OK;
            alloc_reg   <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= (i == MAX_ORDER) ? '0 : LINK_NIL;
            end
        end
        else if (restart)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= (ORD_W'(i) == init_order) ? '0 : LINK_NIL;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ret_reg     <= ret_next;
            clr_hi_reg  <= clr_hi_next;
            status_reg  <= status_next;
            alloc_reg   <= alloc_next;
            if (head_we)
            begin
                head_reg[ord_reg] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg  <= ord_next;
        idx_reg  <= idx_next;
        node_reg <= node_next;
        bud_reg  <= bud_next;
        size_reg <= size_next;
        link_reg <= link_next;
    end

    // A buddy is only examined below the top order.
    a_merge_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M_CHK) |-> (ord_reg < top_order))
        else $error("merge check above top order");

    // Lists are only unlinked at an order that exists.
    a_remove_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM_WR) |-> (ord_reg <= top_order))
        else $error("list removal at an order above the top");

    // A register write always starts a fresh clearing sweep.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> ((state_reg == S_CLEAR) && (clr_cnt_reg == '0)))
        else $error("reinit did not start the clearing sweep");

endmodule

// ----- tb/sv/tb_buddy_page_allocator_core.sv -----
// Self-checking testbench for the buddy page allocator core.
`timescale 1ns / 1ps

module tb_buddy_page_allocator_core;
    import bpa_pkg::*;

    localparam int NPAGES      = 1 << MAX_ORDER;
    localparam int DRAIN_WAIT  = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 90;
    localparam int CALM_ITEMS  = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    res_t out_item;

    buddy_page_allocator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always #4 clk = ~clk;

    // Mirror of the allocator state: page tags, free list links and list heads.
    tag_t  page_tag [NPAGES];
    link_t link_next [NPAGES];
    link_t link_prev [NPAGES];
    link_t list_head [NUM_LISTS];
    int    top_order;

    res_t pending_results[$];
    logic [ADDR_W-1:0] live_blocks[$];
    logic [ADDR_W-1:0] last_freed;
    int    fail_count;
    bit    idle_on;
    int    cycle_count;

    // Register values written one after the other, each followed by a phase of items.
    logic [CFG_W-1:0] order_plan [5] = '{5'd0, 5'd31, 5'd3, 5'd1, 5'd16};

    // One row of the directed table. Where typed is set, want is the result
    // read straight off the behavior; otherwise the mirror supplies it.
    typedef struct packed {
        req_t req;
        logic typed;
        res_t want;
    } row_t;

    localparam res_t NO_RES = '{status: ST_OK, block_address: '0};

    row_t dir_rows [21] = '{
        '{'{REQ_ALLOC, 17'd0,      28'd0},         1'b1, '{ST_ZERO_SIZE, 28'd0}},
        '{'{REQ_ALLOC, 17'd65537,  28'd0},         1'b1, '{ST_NO_SPACE, 28'd0}},
        '{'{REQ_ALLOC, 17'd65536,  28'h0FFFFFF},   1'b1, '{ST_OK, 28'd0}},
        '{'{REQ_ALLOC, 17'd1,      28'd0},         1'b1, '{ST_NO_SPACE, 28'd0}},
        '{'{REQ_FREE,  17'h1FFFF,  28'h0FFFFFFF},  1'b1, '{ST_BAD_PTR, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0001000},   1'b1, '{ST_NOT_HEAD, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0000000},   1'b1, '{ST_OK, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0000000},   1'b1, '{ST_NOT_USED, 28'd0}},
        '{'{REQ_ALLOC, 17'd1,      28'd0},         1'b1, '{ST_OK, 28'd0}},
        '{'{REQ_ALLOC, 17'd1,      28'd0},         1'b1, '{ST_OK, 28'h0001000}},
        '{'{REQ_ALLOC, 17'd3,      28'd0},         1'b0, NO_RES},
        '{'{REQ_ALLOC, 17'h1FFFF,  28'd0},         1'b1, '{ST_NO_SPACE, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0001000},   1'b1, '{ST_OK, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0FFFF000},  1'b1, '{ST_NOT_HEAD, 28'd0}},
        '{'{REQ_FREE,  17'd0,      28'h0000000},   1'b0, NO_RES},
        '{'{REQ_FREE,  17'd0,      28'h0001000},   1'b0, NO_RES},
        '{'{REQ_FREE,  17'd0,      28'h0004000},   1'b0, NO_RES},
        '{'{REQ_ALLOC, 17'd32768,  28'd0},         1'b0, NO_RES},
        '{'{REQ_ALLOC, 17'd32768,  28'd0},         1'b0, NO_RES},
        '{'{REQ_FREE,  17'd0,      28'h8000000},   1'b0, NO_RES},
        '{'{REQ_FREE,  17'd0,      28'h0000000},   1'b0, NO_RES}
    };

    function automatic void list_push(int idx, int ord);
        link_t h;
        h = list_head[ord];
        if (!h[IDX_W]) link_prev[h[IDX_W-1:0]] = link_t'(idx);
        link_next[idx] = h;
        link_prev[idx] = LINK_NIL;
        list_head[ord] = link_t'(idx);
        page_tag[idx] = '{head: 1'b1, used: 1'b0, order: ORD_W'(ord)};
    endfunction

    function automatic void list_unlink(int idx, int ord);
        link_t p;
        link_t n;
        if (page_tag[idx] != '{head: 1'b1, used: 1'b0, order: ORD_W'(ord)}) return;
        p = link_prev[idx];
        n = link_next[idx];
        if (!p[IDX_W]) link_next[p[IDX_W-1:0]] = n;
        if (!n[IDX_W]) link_prev[n[IDX_W-1:0]] = p;
        if (list_head[ord] == link_t'(idx)) list_head[ord] = n;
        link_next[idx] = LINK_NIL;
        link_prev[idx] = LINK_NIL;
        page_tag[idx] = '{head: 1'b1, used: 1'b1, order: ORD_W'(ord)};
    endfunction

    // A write of total_order leaves one free block of the full region at page zero.
    function automatic void reset_pages(logic [CFG_W-1:0] order_reg);
        top_order = (int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        for (int i = 0; i < NPAGES; i++) begin
            page_tag[i] = '0;
            link_next[i] = LINK_NIL;
            link_prev[i] = LINK_NIL;
        end
        for (int i = 0; i < NUM_LISTS; i++) list_head[i] = LINK_NIL;
        list_push(0, top_order);
    endfunction

    // Apply one request to the mirror and return the result it must produce.
    function automatic res_t allocate_or_free(req_t r);
        res_t res;
        int size;
        int ord;
        int idx;
        int bud;
        int lo;
        int hi;
        longint region_end;
        res = '{status: ST_OK, block_address: '0};
        if (r.req_type == REQ_ALLOC) begin
            size = int'(r.page_count);
            if (size == 0) begin
                res.status = ST_ZERO_SIZE;
                return res;
            end
            ord = 0;
            while ((1 << ord) < size || list_head[ord][IDX_W]) begin
                ord++;
                if (ord > top_order) begin
                    res.status = ST_NO_SPACE;
                    return res;
                end
            end
            idx = int'(list_head[ord][IDX_W-1:0]);
            list_unlink(idx, ord);
            while (ord > 0 && (1 << (ord - 1)) >= size) begin
                ord--;
                list_push(idx + (1 << ord), ord);
            end
            page_tag[idx] = '{head: 1'b1, used: 1'b1, order: ORD_W'(ord)};
            res.block_address = ADDR_W'(longint'(idx) * PAGE_BYTES);
            return res;
        end
        region_end = (longint'(1) << top_order) * PAGE_BYTES;
        if (longint'(r.address) >= region_end || r.address[PAGE_SHIFT-1:0] != '0) begin
            res.status = ST_BAD_PTR;
            return res;
        end
        idx = int'(r.address >> PAGE_SHIFT) & (NPAGES - 1);
        if (!page_tag[idx].head) begin
            res.status = ST_NOT_HEAD;
            return res;
        end
        if (!page_tag[idx].used) begin
            res.status = ST_NOT_USED;
            return res;
        end
        ord = int'(page_tag[idx].order);
        list_push(idx, ord);
        // Keep merging while the buddy is a free head of the same order.
        while (ord < top_order) begin
            bud = idx ^ (1 << ord);
            if (page_tag[bud] != '{head: 1'b1, used: 1'b0, order: ORD_W'(ord)}) break;
            lo = (idx < bud) ? idx : bud;
            hi = (idx < bud) ? bud : idx;
            list_unlink(idx, ord);
            list_unlink(bud, ord);
            list_push(lo, ord + 1);
            page_tag[hi] = '0;
            idx = lo;
            ord++;
        end
        return res;
    endfunction

    // Present one item, wait for it to be taken, then record what must come back.
    // A typed expectation, when given, replaces the mirror's result in the queue.
    task automatic send_item(req_t r, logic typed, res_t want);
        res_t got;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        do @(posedge clk); while (in_stall);
        got = allocate_or_free(r);
        pending_results.push_back(typed ? want : got);
        if (got.status == ST_OK) begin
            if (r.req_type == REQ_ALLOC) begin
                live_blocks.push_back(got.block_address);
            end else begin
                last_freed = r.address;
                for (int i = 0; i < live_blocks.size(); i++) begin
                    if (live_blocks[i] == r.address) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // A quiet stretch before the next register write.
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Mostly allocations and frees of live blocks, sprinkled with broken frees.
    function automatic req_t random_request();
        req_t r;
        int pick;
        int region;
        int j;
        region = 1 << top_order;
        pick = $urandom_range(0, 99);
        r = '{req_type: REQ_ALLOC, page_count: '0, address: ADDR_W'($urandom)};
        if (pick < 45) begin
            r.page_count = CNT_W'($urandom_range(1, (region < 8) ? region : 8));
        end else if (pick < 50) begin
            r.page_count = CNT_W'($urandom_range(1, region + 1));
        end else if (pick < 53) begin
            r.page_count = CNT_W'($urandom);
        end else if (pick < 55) begin
            r.page_count = '0;
        end else begin
            r.req_type = REQ_FREE;
            r.page_count = CNT_W'($urandom);
            j = (live_blocks.size() != 0) ? $urandom_range(0, live_blocks.size() - 1) : 0;
            if (pick < 83 && live_blocks.size() != 0) begin
                r.address = live_blocks[j];
            end else if (pick < 88 && live_blocks.size() != 0) begin
                r.address = live_blocks[j] + ADDR_W'(PAGE_BYTES);
            end else if (pick < 93) begin
                r.address = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom)
                          : ADDR_W'($urandom_range(0, region - 1)) << PAGE_SHIFT;
            end else begin
                r.address = last_freed;
            end
        end
        return r;
    endfunction

    // The result side stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Every result taken is compared with the oldest expectation.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation: status %0d address %h",
                       out_item.status, out_item.block_address);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_item.status);
                    fail_count++;
                end
                if (out_item.block_address != want.block_address) begin
                    $error("block_address: expected %h, actual %h",
                           want.block_address, out_item.block_address);
                    fail_count++;
                end
            end
        end
    end

    // The limit covers the six tag store clears of the run, one after reset and
    // one per register write, plus the items with worst-case gaps and stalls.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        fail_count = 0;
        last_freed = '0;
        idle_on = 1'b1;
        reset_pages(CFG_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_request(), 1'b0, NO_RES);

        foreach (order_plan[p]) begin
            wait_drained();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= order_plan[p];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            reset_pages(order_plan[p]);
            live_blocks.delete();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // The tail of the run goes at full rate on both sides.
                if (p == 4 && k == PHASE_ITEMS - CALM_ITEMS) idle_on = 1'b0;
                send_item(random_request(), 1'b0, NO_RES);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- buddy_page_allocator_core.f -----
design/bpa_pkg.sv
design/bpa_store.sv
design/bpa_engine.sv
design/buddy_page_allocator_core.sv
tb/sv/tb_buddy_page_allocator_core.sv
